// File: rtl/gtpr_pkg.sv
`default_nettype none
package gtpr_pkg;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_RD_CTL  = 3'd1,
      OP_WR_CTL  = 3'd2,
      OP_RD_TVAL = 3'd3,
      OP_WR_TVAL = 3'd4,
      OP_RD_CVAL = 3'd5,
      OP_WR_CVAL = 3'd6
   } opcode_type;

   // control register bit positions
   localparam int CTL_EN  = 0;
   localparam int CTL_MSK = 1;
   localparam int CTL_PND = 2;

   localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  opcode;
      logic        user_mode;
      logic [63:0] write_data;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        access_ok;
      logic        irq_assert;
      logic        irq_level;
   } rsp_type;

   // handshake between the pipeline stages
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage
`default_nettype wire

// File: rtl/generic_timer_phys_regs.sv
// An accepted request beat passes the input register, then the response register.
// Throughput: one beat per cycle unless rsp_stall holds the response register;
// counter, compare and control update as a beat moves from input to response register.
// Reset (synchronous, active high) clears counter, compare, control, armed
// flag, user access enable and both stage valids.
`default_nettype none
module generic_timer_phys_regs (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_opcode,
   input  wire         req_user_mode,
   input  wire  [63:0] req_write_data,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic        rsp_access_ok,
   output logic        rsp_irq_assert,
   output logic        rsp_irq_level,
   input  wire         csr_wr_en,
   input  wire         csr_wr_data
);
   import gtpr_pkg::*;

   req_type       req_beat;
   req_type       s1_beat;
   rsp_type       core_rsp;
   rsp_type       rsp_beat;
   stage_ctl_type s1_ctl;
   logic          out_free;
   logic          uae_ff, uae_in;

   assign req_beat.opcode     = req_opcode;
   assign req_beat.user_mode  = req_user_mode;
   assign req_beat.write_data = req_write_data;

   assign s1_ctl.advance = s1_ctl.valid && out_free;

   assign uae_in = csr_wr_en ? csr_wr_data : uae_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uae_ff <= 1'b0;
      end else begin
         uae_ff <= uae_in;
      end
   end

   gtpr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .advance    (s1_ctl.advance),
      .beat_valid (s1_ctl.valid),
      .beat       (s1_beat)
   );

   gtpr_core u_core (
      .clock              (clock),
      .reset              (reset),
      .fire               (s1_ctl.advance),
      .beat               (s1_beat),
      .user_access_enable (uae_ff),
      .rsp                (core_rsp)
   );

   gtpr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_ctl.advance),
      .rsp_next  (core_rsp),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_read_data  = rsp_beat.read_data;
   assign rsp_access_ok  = rsp_beat.access_ok;
   assign rsp_irq_assert = rsp_beat.irq_assert;
   assign rsp_irq_level  = rsp_beat.irq_level;

endmodule
`default_nettype wire

// File: rtl/gtpr_in_stage.sv
`default_nettype none
module gtpr_in_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire gtpr_pkg::req_type req_beat,
   input  wire                    advance,
   output logic                   beat_valid,
   output gtpr_pkg::req_type      beat
);
   import gtpr_pkg::*;

   logic    valid_ff, valid_in;
   req_type beat_ff, beat_in;
   logic    take;

   // stage is free when empty or when its beat moves on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign beat_in   = take ? req_beat : beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule
`default_nettype wire

// File: rtl/gtpr_core.sv
`default_nettype none
module gtpr_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fire,
   input  wire gtpr_pkg::req_type beat,
   input  wire                    user_access_enable,
   output gtpr_pkg::rsp_type      rsp
);
   import gtpr_pkg::*;

   logic [63:0] count_ff, count_in;
   logic [2:0]  ctl_ff, ctl_in;
   logic [63:0] cmp_ff, cmp_in;
   logic        armed_ff, armed_in;

   opcode_type  op;
   logic [63:0] count_inc;
   logic [63:0] tval_sum;
   logic [31:0] tval_rd;
   logic        refused;

   assign op        = opcode_type'(beat.opcode);
   assign count_inc = count_ff + 64'd1;
   assign tval_sum  = count_ff + {{32{beat.write_data[31]}}, beat.write_data[31:0]};
   assign tval_rd   = cmp_ff[31:0] - count_ff[31:0];
   // opcode 7 is a no-op and is never refused
   assign refused   = (beat.opcode != OP_TICK) && (beat.opcode <= OP_WR_CVAL) &&
                      beat.user_mode && !user_access_enable;

   always_comb begin
      count_in       = count_ff;
      ctl_in         = ctl_ff;
      cmp_in         = cmp_ff;
      armed_in       = armed_ff;
      rsp.read_data  = 64'd0;
      rsp.access_ok  = 1'b1;
      rsp.irq_assert = 1'b0;
      if (fire) begin
         if (beat.opcode == OP_TICK) begin
            count_in = count_inc;
            if (armed_ff && (count_inc >= cmp_ff)) begin
               ctl_in[CTL_PND] = 1'b1;
               armed_in        = 1'b0;
               rsp.irq_assert  = !ctl_ff[CTL_MSK];
            end
         end else if (refused) begin
            rsp.access_ok = 1'b0;
         end else begin
            case (op)
               OP_RD_CTL: begin
                  rsp.read_data = {61'd0, ctl_ff};
               end
               OP_WR_CTL: begin
                  ctl_in   = {beat.write_data[CTL_EN] & ctl_ff[CTL_PND],
                              beat.write_data[1:0]};
                  armed_in = beat.write_data[CTL_EN];
               end
               OP_RD_TVAL: begin
                  rsp.read_data = {32'd0, tval_rd};
               end
               OP_WR_TVAL: begin
                  cmp_in = tval_sum;
                  if (ctl_ff[CTL_EN]) begin
                     ctl_in[CTL_PND] = 1'b0;
                     armed_in        = 1'b1;
                  end
               end
               OP_RD_CVAL: begin
                  rsp.read_data = cmp_ff;
               end
               OP_WR_CVAL: begin
                  cmp_in = beat.write_data;
                  if (ctl_ff[CTL_EN]) begin
                     ctl_in[CTL_PND] = 1'b0;
                     armed_in        = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rsp.irq_level = ctl_in[CTL_EN] && ctl_in[CTL_PND] && !ctl_in[CTL_MSK];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 64'd0;
         ctl_ff   <= 3'd0;
         cmp_ff   <= 64'd0;
         armed_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ctl_ff   <= ctl_in;
         cmp_ff   <= cmp_in;
         armed_ff <= armed_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/gtpr_out_stage.sv
`default_nettype none
module gtpr_out_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire gtpr_pkg::rsp_type rsp_next,
   output logic                   free,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output gtpr_pkg::rsp_type      rsp_beat
);
   import gtpr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (free ? 1'b0 : valid_ff);
   assign rsp_in   = load ? rsp_next : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule
`default_nettype wire
